@@ sv/tpsr_pkg.sv @@
// ----------------------------------------------------------------------------
// tpsr_pkg: shared definitions of the touch panel serial reader
// Sizes, register indexes, microcode control word and handshake structs.
// ----------------------------------------------------------------------------
package tpsr_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int CMD_BITS    = 8;
	localparam int CHAN_LEN    = CMD_BITS + 1 + SAMPLE_BITS;
	localparam int PHASE_W     = $clog2(CHAN_LEN);
	localparam int CMD_IDX_W   = $clog2(CMD_BITS);
	localparam int SUM_W       = SAMPLE_BITS + 4;
	localparam int POS_W       = 12;
	localparam int CNT_W       = 5;
	localparam int ROUND_W     = 4;
	localparam int MAX_ROUNDS  = 16;
	localparam int DIV_W       = 8;
	localparam int DIV_CNT_W   = $clog2(SUM_W + 1);
	localparam int OFF_W       = 12;
	localparam int PC_W        = 4;
	localparam int PROG_LEN    = 12;
	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 32;

	localparam logic [PC_W-1:0] STEP_TAKE = 4'd0;
	localparam logic [PC_W-1:0] STEP_EMIT = 4'd11;

	localparam logic [CNT_W-1:0] RST_SAMPLE_COUNT   = 5'd10;
	localparam logic [7:0]       RST_FIRST_COMMAND  = 8'h90;
	localparam logic [7:0]       RST_SECOND_COMMAND = 8'hD0;
	localparam logic [OFF_W-1:0] RST_HORIZ_OFFSET   = 12'd300;
	localparam logic [DIV_W-1:0] RST_HORIZ_DIVISOR  = 8'd11;
	localparam logic [OFF_W-1:0] RST_VERT_OFFSET    = 12'd180;
	localparam logic [DIV_W-1:0] RST_VERT_DIVISOR   = 8'd15;

	typedef enum logic [2:0] {
		REG_SAMPLE_COUNT   = 3'd0,
		REG_FIRST_COMMAND  = 3'd1,
		REG_SECOND_COMMAND = 3'd2,
		REG_HORIZ_OFFSET   = 3'd3,
		REG_HORIZ_DIVISOR  = 3'd4,
		REG_VERT_OFFSET    = 3'd5,
		REG_VERT_DIVISOR   = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_NOP     = 3'd0,
		OP_TAKE    = 3'd1,
		OP_DIV_AVG = 3'd2,
		OP_DIV_POS = 3'd3,
		OP_SET_POS = 3'd4,
		OP_EMIT    = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		C_NEXT = 2'd0,
		C_ITEM = 2'd1,
		C_DIV  = 2'd2,
		C_OUT  = 2'd3
	} cond_t;

	typedef struct packed {
		op_t             op;
		logic            sel;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} cw_t;

	typedef struct packed {
		op_t  op;
		logic sel;
	} ctl_t;

	typedef struct packed {
		logic fin;
		logic div_busy;
		logic out_free;
	} stat_t;

	typedef struct packed {
		logic [CNT_W-1:0] sample_count;
		logic [7:0]       first_command;
		logic [7:0]       second_command;
		logic [OFF_W-1:0] horiz_offset;
		logic [DIV_W-1:0] horiz_divisor;
		logic [OFF_W-1:0] vert_offset;
		logic [DIV_W-1:0] vert_divisor;
	} cfg_t;

	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] sc);
		logic [CNT_W-1:0] n;
		n = sc;
		if (sc == '0)
			n = CNT_W'(1);
		else if (sc > CNT_W'(MAX_ROUNDS))
			n = CNT_W'(MAX_ROUNDS);
		return n;
	endfunction

endpackage

@@ sv/tpsr_item_if.sv @@
// ----------------------------------------------------------------------------
// tpsr_item_if: input word channel
// One serial clock period: start request and sampled converter bit.
// ----------------------------------------------------------------------------
interface tpsr_item_if;
	logic valid;
	logic ready;
	logic start_req;
	logic miso_bit;

	modport source (output valid, output start_req, output miso_bit, input ready);
	modport sink (input valid, input start_req, input miso_bit, output ready);
endinterface

@@ sv/tpsr_result_if.sv @@
// ----------------------------------------------------------------------------
// tpsr_result_if: result word channel
// Pin levels for the period and the calibrated coordinates.
// ----------------------------------------------------------------------------
interface tpsr_result_if;
	logic        valid;
	logic        ready;
	logic        chip_select_n;
	logic        mosi_bit;
	logic        done_res;
	logic [11:0] pos_x;
	logic [11:0] pos_y;

	modport source (output valid, output chip_select_n, output mosi_bit, output done_res,
		output pos_x, output pos_y, input ready);
	modport sink (input valid, input chip_select_n, input mosi_bit, input done_res,
		input pos_x, input pos_y, output ready);
endinterface

@@ sv/touch_panel_serial_reader_unit.sv @@
// ----------------------------------------------------------------------------
// touch_panel_serial_reader_unit: resistive touch panel serial reader
// Reads both panel channels over a serial converter link, averages a set
// number of rounds and reports calibrated, clamped coordinates.
// ----------------------------------------------------------------------------
// Usage: each word on the item channel stands for one serial clock period and
// carries the start request and the sampled converter bit. For every item
// word exactly one result word comes out on the result channel: chip select,
// the command bit to drive, the done flag and the current coordinates.
// Configuration goes through the APB port; the user writes it only while
// the block is idle, which the block itself does not enforce. An ordinary
// word runs a take and an emit step, and the result register loads in the
// emit step. The word that finishes a measurement first runs four 16-bit
// divisions through the one shared divider, then its emit step.
// One item is in work at a time: the next word is taken once the previous
// result is in the output register.
// Reset: idle, result not valid, coordinates zero, registers at default.
// A stalled receiver holds the result register; the sequencer then waits in
// its emit step and no new item word is taken.
// ----------------------------------------------------------------------------
module touch_panel_serial_reader_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	tpsr_item_if.sink                   item,
	tpsr_result_if.source               result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tpsr_pkg::ADDR_W-1:0] paddr,
	input  logic [tpsr_pkg::DATA_W-1:0] pwdata,
	output logic [tpsr_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	tpsr_pkg::cfg_t  cfg;
	tpsr_pkg::ctl_t  ctl;
	tpsr_pkg::stat_t stat;

	tpsr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tpsr_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.stat       (stat),
		.ctl        (ctl)
	);

	tpsr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.ctl          (ctl),
		.stat         (stat),
		.item_start   (item.start_req),
		.item_miso    (item.miso_bit),
		.result_ready (result.ready),
		.result_valid (result.valid),
		.result_cs_n  (result.chip_select_n),
		.result_mosi  (result.mosi_bit),
		.result_done  (result.done_res),
		.result_x     (result.pos_x),
		.result_y     (result.pos_y)
	);

endmodule

@@ sv/tpsr_regs.sv @@
// ----------------------------------------------------------------------------
// tpsr_regs: configuration register file
// APB-style write/read port over the seven setup registers.
// ----------------------------------------------------------------------------
module tpsr_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tpsr_pkg::ADDR_W-1:0]  paddr,
	input  logic [tpsr_pkg::DATA_W-1:0]  pwdata,
	output logic [tpsr_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output tpsr_pkg::cfg_t               cfg
);

	tpsr_pkg::cfg_t      cfg_q;
	tpsr_pkg::reg_idx_t  idx;
	logic                wr_en;

	assign idx    = tpsr_pkg::reg_idx_t'(paddr[tpsr_pkg::ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_count   <= tpsr_pkg::RST_SAMPLE_COUNT;
			cfg_q.first_command  <= tpsr_pkg::RST_FIRST_COMMAND;
			cfg_q.second_command <= tpsr_pkg::RST_SECOND_COMMAND;
			cfg_q.horiz_offset   <= tpsr_pkg::RST_HORIZ_OFFSET;
			cfg_q.horiz_divisor  <= tpsr_pkg::RST_HORIZ_DIVISOR;
			cfg_q.vert_offset    <= tpsr_pkg::RST_VERT_OFFSET;
			cfg_q.vert_divisor   <= tpsr_pkg::RST_VERT_DIVISOR;
		end else if (wr_en) begin
			unique case (idx)
				tpsr_pkg::REG_SAMPLE_COUNT:
					cfg_q.sample_count <= pwdata[tpsr_pkg::CNT_W-1:0];
				tpsr_pkg::REG_FIRST_COMMAND:  cfg_q.first_command  <= pwdata[7:0];
				tpsr_pkg::REG_SECOND_COMMAND: cfg_q.second_command <= pwdata[7:0];
				tpsr_pkg::REG_HORIZ_OFFSET:
					cfg_q.horiz_offset <= pwdata[tpsr_pkg::OFF_W-1:0];
				tpsr_pkg::REG_HORIZ_DIVISOR:
					cfg_q.horiz_divisor <= pwdata[tpsr_pkg::DIV_W-1:0];
				tpsr_pkg::REG_VERT_OFFSET:
					cfg_q.vert_offset <= pwdata[tpsr_pkg::OFF_W-1:0];
				tpsr_pkg::REG_VERT_DIVISOR:
					cfg_q.vert_divisor <= pwdata[tpsr_pkg::DIV_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			tpsr_pkg::REG_SAMPLE_COUNT:   prdata = tpsr_pkg::DATA_W'(cfg_q.sample_count);
			tpsr_pkg::REG_FIRST_COMMAND:  prdata = tpsr_pkg::DATA_W'(cfg_q.first_command);
			tpsr_pkg::REG_SECOND_COMMAND: prdata = tpsr_pkg::DATA_W'(cfg_q.second_command);
			tpsr_pkg::REG_HORIZ_OFFSET:   prdata = tpsr_pkg::DATA_W'(cfg_q.horiz_offset);
			tpsr_pkg::REG_HORIZ_DIVISOR:  prdata = tpsr_pkg::DATA_W'(cfg_q.horiz_divisor);
			tpsr_pkg::REG_VERT_OFFSET:    prdata = tpsr_pkg::DATA_W'(cfg_q.vert_offset);
			tpsr_pkg::REG_VERT_DIVISOR:   prdata = tpsr_pkg::DATA_W'(cfg_q.vert_divisor);
			default:                      prdata = '0;
		endcase
	end

endmodule

@@ sv/tpsr_seq.sv @@
// ----------------------------------------------------------------------------
// tpsr_seq: microcode sequencer
// Step counter over a read-only program; each step issues one datapath
// operation and holds, advances or jumps on a condition.
// ----------------------------------------------------------------------------
module tpsr_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  tpsr_pkg::stat_t stat,
	output tpsr_pkg::ctl_t  ctl
);

	localparam tpsr_pkg::cw_t PROG [tpsr_pkg::PROG_LEN] = '{
		// take one word; measurement end falls through into the scaling code
		'{tpsr_pkg::OP_TAKE,    1'b0, tpsr_pkg::C_ITEM, tpsr_pkg::STEP_EMIT},
		'{tpsr_pkg::OP_DIV_AVG, 1'b0, tpsr_pkg::C_NEXT, tpsr_pkg::STEP_TAKE},
		'{tpsr_pkg::OP_NOP,     1'b0, tpsr_pkg::C_DIV,  tpsr_pkg::STEP_TAKE},
		'{tpsr_pkg::OP_DIV_POS, 1'b0, tpsr_pkg::C_NEXT, tpsr_pkg::STEP_TAKE},
		'{tpsr_pkg::OP_NOP,     1'b0, tpsr_pkg::C_DIV,  tpsr_pkg::STEP_TAKE},
		'{tpsr_pkg::OP_SET_POS, 1'b0, tpsr_pkg::C_NEXT, tpsr_pkg::STEP_TAKE},
		'{tpsr_pkg::OP_DIV_AVG, 1'b1, tpsr_pkg::C_NEXT, tpsr_pkg::STEP_TAKE},
		'{tpsr_pkg::OP_NOP,     1'b1, tpsr_pkg::C_DIV,  tpsr_pkg::STEP_TAKE},
		'{tpsr_pkg::OP_DIV_POS, 1'b1, tpsr_pkg::C_NEXT, tpsr_pkg::STEP_TAKE},
		'{tpsr_pkg::OP_NOP,     1'b1, tpsr_pkg::C_DIV,  tpsr_pkg::STEP_TAKE},
		'{tpsr_pkg::OP_SET_POS, 1'b1, tpsr_pkg::C_NEXT, tpsr_pkg::STEP_TAKE},
		'{tpsr_pkg::OP_EMIT,    1'b0, tpsr_pkg::C_OUT,  tpsr_pkg::STEP_TAKE}
	};

	logic [tpsr_pkg::PC_W-1:0] pc_q;
	logic [tpsr_pkg::PC_W-1:0] pc_d;
	logic [tpsr_pkg::PC_W-1:0] pc_inc;
	tpsr_pkg::cw_t             cw;
	logic                      fire;

	assign cw         = PROG[pc_q];
	assign pc_inc     = pc_q + tpsr_pkg::PC_W'(1);
	assign item_ready = (cw.cond == tpsr_pkg::C_ITEM);

	always_comb begin
		fire = 1'b0;
		pc_d = pc_q;
		unique case (cw.cond)
			tpsr_pkg::C_NEXT: begin
				fire = 1'b1;
				pc_d = pc_inc;
			end
			tpsr_pkg::C_ITEM: begin
				fire = item_valid;
				if (item_valid)
					pc_d = stat.fin ? pc_inc : cw.target;
			end
			tpsr_pkg::C_DIV: begin
				// hold until the divider has run its last step
				if (!stat.div_busy)
					pc_d = pc_inc;
			end
			tpsr_pkg::C_OUT: begin
				fire = stat.out_free;
				if (stat.out_free)
					pc_d = cw.target;
			end
			default: pc_d = tpsr_pkg::STEP_TAKE;
		endcase
		ctl.op  = fire ? cw.op : tpsr_pkg::OP_NOP;
		ctl.sel = cw.sel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= tpsr_pkg::STEP_TAKE;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

@@ sv/tpsr_div.sv @@
// ----------------------------------------------------------------------------
// tpsr_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module tpsr_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tpsr_pkg::SUM_W-1:0]  dividend,
	input  logic [tpsr_pkg::DIV_W-1:0]  divisor,
	output logic [tpsr_pkg::SUM_W-1:0]  quo,
	output logic                        busy
);

	logic [tpsr_pkg::DIV_W-1:0]     rem_q;
	logic [tpsr_pkg::DIV_W-1:0]     dvs_q;
	logic [tpsr_pkg::SUM_W-1:0]     quo_q;
	logic [tpsr_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [tpsr_pkg::DIV_W:0]       trial;
	logic [tpsr_pkg::DIV_W:0]       diff;
	logic                           ge;

	assign trial = {rem_q, quo_q[tpsr_pkg::SUM_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};
	assign quo   = quo_q;
	assign busy  = (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= tpsr_pkg::DIV_CNT_W'(tpsr_pkg::SUM_W);
		end else if (busy) begin
			cnt_q <= cnt_q - tpsr_pkg::DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy) begin
			rem_q <= ge ? diff[tpsr_pkg::DIV_W-1:0] : trial[tpsr_pkg::DIV_W-1:0];
			quo_q <= {quo_q[tpsr_pkg::SUM_W-2:0], ge};
		end
	end

endmodule

@@ sv/tpsr_dp.sv @@
// ----------------------------------------------------------------------------
// tpsr_dp: serial read datapath
// Bit phase, channel and round counters, shift-in and sums, scaling and
// the result output register.
// ----------------------------------------------------------------------------
module tpsr_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tpsr_pkg::cfg_t              cfg,
	input  tpsr_pkg::ctl_t              ctl,
	output tpsr_pkg::stat_t             stat,
	input  logic                        item_start,
	input  logic                        item_miso,
	input  logic                        result_ready,
	output logic                        result_valid,
	output logic                        result_cs_n,
	output logic                        result_mosi,
	output logic                        result_done,
	output logic [tpsr_pkg::POS_W-1:0]  result_x,
	output logic [tpsr_pkg::POS_W-1:0]  result_y
);

	logic                             active_q;
	logic [tpsr_pkg::PHASE_W-1:0]     phase_q;
	logic                             chan_q;
	logic [tpsr_pkg::ROUND_W-1:0]     round_q;
	logic [tpsr_pkg::SAMPLE_BITS-1:0] shift_q;
	logic [tpsr_pkg::SUM_W-1:0]       sum1_q;
	logic [tpsr_pkg::SUM_W-1:0]       sum2_q;
	logic [tpsr_pkg::POS_W-1:0]       last_x_q;
	logic [tpsr_pkg::POS_W-1:0]       last_y_q;
	logic                             cs_n_q;
	logic                             mosi_q;
	logic                             done_q;
	logic                             out_valid_q;
	logic [tpsr_pkg::POS_W-1:0]       out_x_q;
	logic [tpsr_pkg::POS_W-1:0]       out_y_q;
	logic                             out_cs_n_q;
	logic                             out_mosi_q;
	logic                             out_done_q;

	logic                             act_d;
	logic [tpsr_pkg::PHASE_W-1:0]     ph_d;
	logic                             ch_d;
	logic [tpsr_pkg::ROUND_W-1:0]     rnd_d;
	logic [tpsr_pkg::SAMPLE_BITS-1:0] sh_d;
	logic [tpsr_pkg::SUM_W-1:0]       s1_d;
	logic [tpsr_pkg::SUM_W-1:0]       s2_d;
	logic                             cs_n_d;
	logic                             mosi_d;
	logic                             fin;
	logic [7:0]                       cmd;
	logic [tpsr_pkg::CNT_W-1:0]       n;

	logic                             div_start;
	logic [tpsr_pkg::SUM_W-1:0]       div_dividend;
	logic [tpsr_pkg::DIV_W-1:0]       div_divisor;
	logic [tpsr_pkg::SUM_W-1:0]       quo;
	logic                             div_busy;
	logic [tpsr_pkg::OFF_W-1:0]       off;
	logic [tpsr_pkg::DIV_W-1:0]       dv;
	logic [tpsr_pkg::POS_W-1:0]       pos;
	logic                             out_free;

	assign n        = tpsr_pkg::eff_count(cfg.sample_count);
	assign out_free = !out_valid_q || result_ready;

	assign stat.fin      = fin;
	assign stat.div_busy = div_busy;
	assign stat.out_free = out_free;

	// per-word update of the serial sequence
	always_comb begin
		act_d  = active_q;
		ph_d   = phase_q;
		ch_d   = chan_q;
		rnd_d  = round_q;
		sh_d   = shift_q;
		s1_d   = sum1_q;
		s2_d   = sum2_q;
		cs_n_d = 1'b1;
		mosi_d = 1'b0;
		fin    = 1'b0;
		cmd    = chan_q ? cfg.second_command : cfg.first_command;
		if (!active_q && item_start) begin
			act_d = 1'b1;
			ph_d  = '0;
			ch_d  = 1'b0;
			rnd_d = '0;
			sh_d  = '0;
			s1_d  = '0;
			s2_d  = '0;
			cmd   = cfg.first_command;
		end
		if (act_d) begin
			cs_n_d = 1'b0;
			if (ph_d >= tpsr_pkg::PHASE_W'(tpsr_pkg::CHAN_LEN))
				ph_d = '0;
			if (ph_d < tpsr_pkg::PHASE_W'(tpsr_pkg::CMD_BITS)) begin
				mosi_d = cmd[tpsr_pkg::CMD_IDX_W'(tpsr_pkg::CMD_BITS - 1)
					- ph_d[tpsr_pkg::CMD_IDX_W-1:0]];
				ph_d = ph_d + tpsr_pkg::PHASE_W'(1);
			end else if (ph_d == tpsr_pkg::PHASE_W'(tpsr_pkg::CMD_BITS)) begin
				// busy clock between command and data
				ph_d = ph_d + tpsr_pkg::PHASE_W'(1);
			end else begin
				sh_d = {sh_d[tpsr_pkg::SAMPLE_BITS-2:0], item_miso};
				if (ph_d == tpsr_pkg::PHASE_W'(tpsr_pkg::CHAN_LEN - 1)) begin
					if (ch_d)
						s2_d = s2_d + tpsr_pkg::SUM_W'(sh_d);
					else
						s1_d = s1_d + tpsr_pkg::SUM_W'(sh_d);
					sh_d = '0;
					ph_d = '0;
					if (!ch_d) begin
						ch_d = 1'b1;
					end else begin
						ch_d = 1'b0;
						if ({1'b0, rnd_d} + tpsr_pkg::CNT_W'(1) >= n) begin
							fin   = 1'b1;
							act_d = 1'b0;
							rnd_d = '0;
						end else begin
							rnd_d = rnd_d + tpsr_pkg::ROUND_W'(1);
						end
					end
				end else begin
					ph_d = ph_d + tpsr_pkg::PHASE_W'(1);
				end
			end
		end
	end

	// divider operand selection
	always_comb begin
		off          = ctl.sel ? cfg.vert_offset : cfg.horiz_offset;
		dv           = ctl.sel ? cfg.vert_divisor : cfg.horiz_divisor;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = tpsr_pkg::DIV_W'(1);
		case (ctl.op)
			tpsr_pkg::OP_DIV_AVG: begin
				div_start    = 1'b1;
				div_dividend = ctl.sel ? sum2_q : sum1_q;
				div_divisor  = tpsr_pkg::DIV_W'(n);
			end
			tpsr_pkg::OP_DIV_POS: begin
				div_start = 1'b1;
				// negative difference clamps to zero
				if (quo > tpsr_pkg::SUM_W'(off))
					div_dividend = quo - tpsr_pkg::SUM_W'(off);
				div_divisor = (dv == '0) ? tpsr_pkg::DIV_W'(1) : dv;
			end
			default: ;
		endcase
	end

	assign pos = (|quo[tpsr_pkg::SUM_W-1:tpsr_pkg::POS_W]) ? '1 : quo[tpsr_pkg::POS_W-1:0];

	tpsr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quo      (quo),
		.busy     (div_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			phase_q  <= '0;
			chan_q   <= 1'b0;
			round_q  <= '0;
			shift_q  <= '0;
			sum1_q   <= '0;
			sum2_q   <= '0;
			last_x_q <= '0;
			last_y_q <= '0;
		end else begin
			case (ctl.op)
				tpsr_pkg::OP_TAKE: begin
					active_q <= act_d;
					phase_q  <= ph_d;
					chan_q   <= ch_d;
					round_q  <= rnd_d;
					shift_q  <= sh_d;
					sum1_q   <= s1_d;
					sum2_q   <= s2_d;
				end
				tpsr_pkg::OP_SET_POS: begin
					if (ctl.sel)
						last_y_q <= pos;
					else
						last_x_q <= pos;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == tpsr_pkg::OP_TAKE) begin
			cs_n_q <= cs_n_d;
			mosi_q <= mosi_d;
			done_q <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.op == tpsr_pkg::OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == tpsr_pkg::OP_EMIT) begin
			out_cs_n_q <= cs_n_q;
			out_mosi_q <= mosi_q;
			out_done_q <= done_q;
			out_x_q    <= last_x_q;
			out_y_q    <= last_y_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result_cs_n  = out_cs_n_q;
	assign result_mosi  = out_mosi_q;
	assign result_done  = out_done_q;
	assign result_x     = out_x_q;
	assign result_y     = out_y_q;

endmodule
